// ----- rtl/bffpa_pkg.sv -----
// Shared types and constants of the bitmap first-fit page allocator.
`timescale 1ns / 1ps

package bffpa_pkg;

   // Field widths of the request and response items.
   localparam int OP_W     = 1;
   localparam int COUNT_W  = 13;
   localparam int START_W  = 12;
   localparam int STATUS_W = 2;
   localparam int FIRST_W  = 12;

   // The bitmap is held as slices of eight page bits, one slice per memory word.
   localparam int SLICE_W    = 8;
   localparam int SLICE_BITS = 3;

   // Wide enough to hold any map size up to and including 65536 pages.
   localparam int SIZE_W = 17;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_NO_SPACE = 2'd1,
      ST_BAD_FREE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_SCAN,
      S_CHECK,
      S_SET,
      S_CLEAR,
      S_RESULT
   } fsm_state_type;

   // Outcome of scanning one slice for the end of a free run.
   typedef struct packed {
      logic                  hit;
      logic [SLICE_BITS-1:0] pos;
      logic [COUNT_W-1:0]    run;
   } scan_res_type;

endpackage

// ----- rtl/bffpa_run_scan.sv -----
// Run scanner: walks one eight-page slice and finds where a free run reaches its length.
`timescale 1ns / 1ps

module bffpa_run_scan (
   input  logic [bffpa_pkg::SLICE_W-1:0] free_bits,
   input  logic [bffpa_pkg::COUNT_W-1:0] run_in,
   input  logic [bffpa_pkg::COUNT_W-1:0] count,
   output bffpa_pkg::scan_res_type       res
);
   import bffpa_pkg::*;

   // The run length is carried from page to page; the first page at which it
   // equals the requested count is the last page of the lowest fitting run.
   always_comb begin
      logic [COUNT_W-1:0]    run;
      logic                  hit;
      logic [SLICE_BITS-1:0] pos;
      run = run_in;
      hit = 1'b0;
      pos = '0;
      for (int i = 0; i < SLICE_W; i++) begin
         if (free_bits[i]) begin
            run = run + COUNT_W'(1);
         end else begin
            run = '0;
         end
         if (!hit && run == count) begin
            hit = 1'b1;
            pos = SLICE_BITS'(i);
         end
      end
      res.hit = hit;
      res.pos = pos;
      res.run = run;
   end

endmodule

// ----- rtl/bitmap_first_fit_page_allocator_core.sv -----
// Top level of the bitmap first-fit page allocator: sequencer, bitmap memory and result register.
`timescale 1ns / 1ps

// The allocator keeps one used bit per page in a memory of eight-bit slices and
// serves one item at a time. After reset it runs a clearing pass over all
// ceil(PAGE_TOTAL/8) slices, marking only page 0 as used, and accepts no item
// until that pass is over. An allocate item scans the slices from page 0 at one
// slice per cycle through a single run scanner, stops at the first slice where a
// free run of page_count pages ends, and then marks the run in a read-modify-write
// pass of one slice per cycle; a failed allocate walks the whole map. A free item
// makes a check pass over the slices of its range and, only if every page is
// used, a clearing pass over the same slices. Items that are rejected on their
// fields alone go straight to the result state without reading the memory. The
// pace is set by the single eight-bit memory port and the run scanner behind it.
// The result sits in an output register, so a slow consumer holds the block only
// once the next result is ready to be written.
module bitmap_first_fit_page_allocator_core #(
   parameter int PAGE_TOTAL = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [bffpa_pkg::OP_W-1:0]     req_op,
   input  logic [bffpa_pkg::COUNT_W-1:0]  req_page_count,
   input  logic [bffpa_pkg::START_W-1:0]  req_start_page,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [bffpa_pkg::STATUS_W-1:0] rsp_status,
   output logic [bffpa_pkg::FIRST_W-1:0]  rsp_first_page
);
   import bffpa_pkg::*;

   localparam int NUM_WORDS = (PAGE_TOTAL + SLICE_W - 1) / SLICE_W;
   localparam int WW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int PGW       = WW + SLICE_BITS;
   localparam int EW        = ((PGW > COUNT_W) ? PGW : COUNT_W) + 1;
   localparam int FW        = (PGW > FIRST_W) ? PGW : FIRST_W;

   localparam logic [SIZE_W-1:0] PAGE_TOTAL_L = SIZE_W'(PAGE_TOTAL);
   localparam logic [PGW:0]      PAGE_TOTAL_P = (PGW + 1)'(PAGE_TOTAL);
   localparam logic [WW:0]       NUM_WORDS_C  = (WW + 1)'(NUM_WORDS);
   localparam logic [WW:0]       LAST_ISS     = (WW + 1)'(NUM_WORDS - 1);
   localparam logic [WW-1:0]     LAST_WORD    = WW'(NUM_WORDS - 1);

   // Sequencer state.
   fsm_state_type        state_ff, state_in;
   logic [WW:0]          iss_ff, iss_in;
   logic [COUNT_W-1:0]   run_ff, run_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [PGW-1:0]       lo_ff, lo_in;
   logic [PGW-1:0]       hi_ff, hi_in;
   logic                 ok_ff, ok_in;
   status_type           res_status_ff, res_status_in;
   logic [FIRST_W-1:0]   res_first_ff, res_first_in;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [FIRST_W-1:0]   rsp_first_page_ff, rsp_first_page_in;

   // Bitmap memory and its registered read port.
   logic [SLICE_W-1:0]   mem [NUM_WORDS];
   logic                 rd_en;
   logic [WW-1:0]        rd_addr;
   logic                 rd_vld_ff;
   logic [SLICE_W-1:0]   rd_data_ff;
   logic [WW-1:0]        rd_word_ff;
   logic                 wr_en;
   logic [WW-1:0]        wr_addr;
   logic [SLICE_W-1:0]   wr_data;

   // Per-slice helpers.
   logic [WW-1:0]        lo_w, hi_w;
   logic [SLICE_BITS-1:0] lo_b, hi_b;
   logic [SLICE_W-1:0]   in_rng;
   logic [SLICE_W-1:0]   in_map;
   logic [SLICE_W-1:0]   free_bits;
   scan_res_type         scan_res;
   logic [EW-1:0]        end_e, first_e;
   logic [PGW-1:0]       first_pg;
   logic [FW-1:0]        first_fw;
   logic [SIZE_W-1:0]    free_end;
   logic [PGW-1:0]       start_pg;
   logic                 last_word;
   logic                 ok_now;

   assign lo_w = lo_ff[PGW-1:SLICE_BITS];
   assign hi_w = hi_ff[PGW-1:SLICE_BITS];
   assign lo_b = lo_ff[SLICE_BITS-1:0];
   assign hi_b = hi_ff[SLICE_BITS-1:0];
   assign rd_addr = iss_ff[WW-1:0];
   assign last_word = (rd_word_ff == hi_w);

   // Which bits of the slice just read fall inside the current range, and which
   // lie inside the map at all; pages past the end always count as used.
   always_comb begin
      for (int i = 0; i < SLICE_W; i++) begin
         in_rng[i] = ((rd_word_ff > lo_w) || (SLICE_BITS'(i) >= lo_b)) &&
                     ((rd_word_ff < hi_w) || (SLICE_BITS'(i) <= hi_b));
         in_map[i] = ({1'b0, rd_word_ff, SLICE_BITS'(i)} < PAGE_TOTAL_P);
      end
   end

   assign free_bits = ~rd_data_ff & in_map;

   bffpa_run_scan u_run_scan (
      .free_bits (free_bits),
      .run_in    (run_ff),
      .count     (count_ff),
      .res       (scan_res)
   );

   // The run ends at the page where the scanner hit; its first page lies
   // count - 1 pages below.
   assign end_e    = EW'({rd_word_ff, scan_res.pos});
   assign first_e  = end_e + EW'(1) - EW'(count_ff);
   assign first_pg = first_e[PGW-1:0];
   assign first_fw = FW'(first_pg);
   assign free_end = SIZE_W'(req_start_page) + SIZE_W'(req_page_count);
   assign start_pg = PGW'(req_start_page);
   assign ok_now   = ok_ff & (&(rd_data_ff | ~in_rng));

   always_comb begin
      state_in          = state_ff;
      iss_in            = iss_ff;
      run_in            = run_ff;
      count_in          = count_ff;
      lo_in             = lo_ff;
      hi_in             = hi_ff;
      ok_in             = ok_ff;
      res_status_in     = res_status_ff;
      res_first_in      = res_first_ff;
      rsp_valid_in      = rsp_valid_ff & ~rsp_ready;
      rsp_status_in     = rsp_status_ff;
      rsp_first_page_in = rsp_first_page_ff;
      req_ready         = 1'b0;
      rd_en             = 1'b0;
      wr_en             = 1'b0;
      wr_addr           = rd_word_ff;
      wr_data           = rd_data_ff;

      unique case (state_ff)
         S_INIT: begin
            // Clearing pass: every slice is zeroed, page 0 stays reserved.
            wr_en   = 1'b1;
            wr_addr = iss_ff[WW-1:0];
            wr_data = (iss_ff == '0) ? SLICE_W'(1) : '0;
            iss_in  = iss_ff + (WW + 1)'(1);
            if (iss_ff == LAST_ISS) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               iss_in       = '0;
               run_in       = '0;
               ok_in        = 1'b1;
               count_in     = req_page_count;
               res_first_in = '0;
               if (req_op == OP_ALLOC) begin
                  if (req_page_count == '0 ||
                      SIZE_W'(req_page_count) > PAGE_TOTAL_L) begin
                     res_status_in = ST_NO_SPACE;
                     state_in      = S_RESULT;
                  end else begin
                     state_in = S_SCAN;
                  end
               end else begin
                  if (req_page_count == '0 || free_end > PAGE_TOTAL_L) begin
                     res_status_in = ST_BAD_FREE;
                     state_in      = S_RESULT;
                  end else begin
                     lo_in    = start_pg;
                     hi_in    = PGW'(free_end - SIZE_W'(1));
                     iss_in   = {1'b0, start_pg[PGW-1:SLICE_BITS]};
                     state_in = S_CHECK;
                  end
               end
            end
         end

         S_SCAN: begin
            // Reads stop as soon as the run is found, so no stale slice
            // follows into the marking pass.
            rd_en = (iss_ff < NUM_WORDS_C) && !(rd_vld_ff && scan_res.hit);
            if (rd_en) begin
               iss_in = iss_ff + (WW + 1)'(1);
            end
            if (rd_vld_ff) begin
               run_in = scan_res.run;
               if (scan_res.hit) begin
                  lo_in        = first_pg;
                  hi_in        = {rd_word_ff, scan_res.pos};
                  iss_in       = {1'b0, first_pg[PGW-1:SLICE_BITS]};
                  res_first_in = first_fw[FIRST_W-1:0];
                  state_in     = S_SET;
               end else if (rd_word_ff == LAST_WORD) begin
                  res_status_in = ST_NO_SPACE;
                  state_in      = S_RESULT;
               end
            end
         end

         S_CHECK: begin
            rd_en = (iss_ff <= {1'b0, hi_w});
            if (rd_en) begin
               iss_in = iss_ff + (WW + 1)'(1);
            end
            if (rd_vld_ff) begin
               ok_in = ok_now;
               if (last_word) begin
                  if (ok_now) begin
                     iss_in   = {1'b0, lo_w};
                     state_in = S_CLEAR;
                  end else begin
                     res_status_in = ST_BAD_FREE;
                     state_in      = S_RESULT;
                  end
               end
            end
         end

         S_SET: begin
            rd_en = (iss_ff <= {1'b0, hi_w});
            if (rd_en) begin
               iss_in = iss_ff + (WW + 1)'(1);
            end
            if (rd_vld_ff) begin
               wr_en   = 1'b1;
               wr_data = rd_data_ff | in_rng;
               if (last_word) begin
                  res_status_in = ST_OK;
                  state_in      = S_RESULT;
               end
            end
         end

         S_CLEAR: begin
            rd_en = (iss_ff <= {1'b0, hi_w});
            if (rd_en) begin
               iss_in = iss_ff + (WW + 1)'(1);
            end
            if (rd_vld_ff) begin
               wr_en   = 1'b1;
               wr_data = rd_data_ff & ~in_rng;
               if (last_word) begin
                  res_status_in = ST_OK;
                  state_in      = S_RESULT;
               end
            end
         end

         S_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_status_in     = res_status_ff;
               rsp_first_page_in = res_first_ff;
               state_in          = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         iss_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iss_ff       <= iss_in;
         rd_vld_ff    <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff            <= run_in;
      count_ff          <= count_in;
      lo_ff             <= lo_in;
      hi_ff             <= hi_in;
      ok_ff             <= ok_in;
      res_status_ff     <= res_status_in;
      res_first_ff      <= res_first_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_first_page_ff <= rsp_first_page_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_word_ff <= rd_addr;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_first_page = rsp_first_page_ff;

   // A slice arrives from memory only while a pass is running to consume it.
   a_read_in_pass: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == S_SCAN || state_ff == S_CHECK ||
                     state_ff == S_SET || state_ff == S_CLEAR))
      else $error("slice read returned outside a pass");

   // The bitmap is never written while the block waits for or reports an item.
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff != S_IDLE && state_ff != S_RESULT))
      else $error("bitmap written while idle");

   // Marking writes stay within the slices of the found run.
   a_set_in_range: assert property (@(posedge clock) disable iff (reset)
      (wr_en && state_ff == S_SET) |-> (wr_addr >= lo_w && wr_addr <= hi_w))
      else $error("run marking outside its slices");

   // Only a successful allocation reports a non-zero first page.
   a_first_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> (rsp_first_page_ff == '0))
      else $error("first page set on a failed item");

endmodule
